// ===== design/hemisphere_direction_sampler_assert.svh =====
`ifndef HEMISPHERE_DIRECTION_SAMPLER_ASSERT_SVH
`define HEMISPHERE_DIRECTION_SAMPLER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hds: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define HDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hds: next-cycle check failed");

`endif

// ===== design/hds_pkg.sv =====
package hds_pkg;

    // Rotation steps of the sine/cosine unit
    localparam int CORDIC_STEPS = 32;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/hds_delay.sv =====
module hds_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_pipe [0:D-1];

    // Advance the line on every enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int j = 1; j < D; j++) begin
                r_pipe[j] <= r_pipe[j-1];
            end
        end
    end

    assign o_q = r_pipe[D-1];
endmodule

// ===== design/hds_sqrt.sv =====
module hds_sqrt #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_rad,
    output logic [W/2:0]   o_root
);
    localparam int H = W / 2;

    logic [W-1:0] r_x    [0:H-2];
    logic [H-1:0] r_root [0:H-1];
    logic [H+1:0] r_rem  [0:H-1];
    logic [H:0]   r_out;

    // One root bit per stage, two radicand bits shifted in each time
    for (genvar j = 0; j < H; j++) begin : g_step
        logic [W-1:0] x_in;
        logic [H-1:0] root_in;
        logic [H+1:0] rem_in;
        logic [H+1:0] rem_sh;
        logic [H+1:0] trial;
        if (j == 0) begin : g_first
            assign x_in    = i_rad;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign x_in    = r_x[j-1];
            assign root_in = r_root[j-1];
            assign rem_in  = r_rem[j-1];
        end
        assign rem_sh = {rem_in[H-1:0], x_in[W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= trial) begin
                    r_rem[j]  <= rem_sh - trial;
                    r_root[j] <= {root_in[H-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= rem_sh;
                    r_root[j] <= {root_in[H-2:0], 1'b0};
                end
            end
        end

        if (j < H - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j] <= {x_in[W-3:0], 2'b00};
                end
            end
        end
    end

    // Round to nearest: bump when the remainder exceeds the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_rem[H-1] > (H+2)'(r_root[H-1])) begin
                r_out <= (H+1)'(r_root[H-1]) + (H+1)'(1);
            end else begin
                r_out <= (H+1)'(r_root[H-1]);
            end
        end
    end

    assign o_root = r_out;
endmodule

// ===== design/hds_div.sv =====
module hds_div #(
    parameter int FRAC_BITS = 15,
    parameter int VW = 17,
    parameter int LW = 17
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [VW-1:0]     i_val,
    input  logic [LW-1:0]            i_len,
    output logic signed [FRAC_BITS+1:0] o_q
);
    localparam int Q  = FRAC_BITS + 1;
    localparam int NW = VW + FRAC_BITS + 1;

    logic [VW-1:0] w_mag;
    logic [NW-1:0] w_num;

    logic [LW:0]   r_rem  [0:Q-1];
    logic [Q-1:0]  r_lo   [0:Q];
    logic [LW-1:0] r_len  [0:Q-1];
    logic          r_neg  [0:Q];
    logic          r_zero [0:Q];
    logic signed [FRAC_BITS+1:0] r_q;

    // Scale the magnitude and add half the divisor for rounding
    assign w_mag = i_val[VW-1] ? VW'(-i_val) : VW'(i_val);
    assign w_num = (NW'(w_mag) << FRAC_BITS) + NW'(i_len >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (LW+1)'(w_num >> Q);
            r_lo[0]   <= Q'(w_num);
            r_len[0]  <= i_len;
            r_neg[0]  <= i_val[VW-1];
            r_zero[0] <= (i_len == '0);
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 1; j <= Q; j++) begin : g_step
        logic [LW:0] rem_sh;
        logic        ge;
        assign rem_sh = {r_rem[j-1][LW-1:0], r_lo[j-1][Q-1]};
        assign ge     = (rem_sh >= {1'b0, r_len[j-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[j]   <= {r_lo[j-1][Q-2:0], ge};
                r_neg[j]  <= r_neg[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end

        if (j < Q) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? (rem_sh - {1'b0, r_len[j-1]}) : rem_sh;
                    r_len[j] <= r_len[j-1];
                end
            end
        end
    end

    // Restore the sign, drop the result for a zero length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[Q]) begin
                r_q <= '0;
            end else if (r_neg[Q]) begin
                r_q <= -$signed({1'b0, r_lo[Q]});
            end else begin
                r_q <= $signed({1'b0, r_lo[Q]});
            end
        end
    end

    assign o_q = r_q;
endmodule

// ===== design/hds_cordic.sv =====
module hds_cordic #(
    parameter int FRAC_BITS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [31:0]                 i_phase,
    output logic signed [FRAC_BITS+2:0] o_cos,
    output logic signed [FRAC_BITS+2:0] o_sin
);
    import hds_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam int ZW = 34;
    localparam int N  = CORDIC_STEPS;
    localparam logic [63:0] K_FULL =
        (64'd2608131496 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    logic [1:0]  w_quad;
    logic [31:0] w_resid;

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];
    logic signed [XW-1:0] r_cos;
    logic signed [XW-1:0] r_sin;

    // Split off the nearest quarter turn
    assign w_quad  = 2'((i_phase + 32'h2000_0000) >> 30);
    assign w_resid = i_phase - {w_quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= XW'(K_FULL);
            r_y[0] <= '0;
            r_z[0] <= ZW'($signed(w_resid));
            r_q[0] <= w_quad;
        end
    end

    // Rotate toward zero residual angle
    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({2'b00, f_atan(i)});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({2'b00, f_atan(i)});
                end
            end
        end
    end

    // Apply the quarter turn by swaps and negations
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[N])
                2'd1: begin
                    r_cos <= -r_y[N];
                    r_sin <= r_x[N];
                end
                2'd2: begin
                    r_cos <= -r_x[N];
                    r_sin <= -r_y[N];
                end
                2'd3: begin
                    r_cos <= r_y[N];
                    r_sin <= -r_x[N];
                end
                default: begin
                    r_cos <= r_x[N];
                    r_sin <= r_y[N];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// ===== design/hemisphere_direction_sampler.sv =====
// Channel  Dir  Fields (lowest bit first)                                  Width
// s_axis   in   normal_x/y/z, rand_height, rand_turn, origin_x/y/z         176
// m_axis   out  ray_origin_x/y/z, dir_x/y/z                                144
//
// One transaction per cycle in each direction while the output is not stalled.
// Latency is set by the serial chain tangent sqrt, divide, bitangent sqrt, divide.
// Reset clears only the valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline in place; input is taken
// whenever the output register is empty or is being drained.
module hemisphere_direction_sampler #(
    parameter int FRAC_BITS = 15,
    parameter int RAND_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // normal_x, normal_y, normal_z, rand_height, rand_turn, origin_x, origin_y, origin_z
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ray_origin_x, ray_origin_y, ray_origin_z, dir_x, dir_y, dir_z
    output logic [143:0] m_axis_tdata
);
    import hds_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int NW    = F + 2;
    localparam int BW    = F + 3;
    localparam int CW    = ((16 + F > RAND_BITS) ? 16 + F : RAND_BITS) + 1;
    localparam int RW    = 2 * F + 2;
    localparam int LS1   = F + 2;
    localparam int LS2   = F + 3;
    localparam int LD    = F + 3;
    localparam int LC    = CORDIC_STEPS + 2;
    localparam int T_TAN = 3 + LS1 + LD;
    localparam int T_BIT = T_TAN + 4 + LS2 + LD;
    localparam int T_OUT = T_BIT + 2;
    localparam int XPW   = 2 * NW;
    localparam int BSQW  = 2 * F + 3;
    localparam int BSSW  = 2 * F + 4;
    localparam int SXPW  = 2 * F + 6;
    localparam int FPW   = 2 * F + 5;
    localparam int SUMW  = FPW + 2;
    localparam int DS    = 2 * F - 15;
    localparam logic [15:0] RMASK =
        (RAND_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RAND_BITS) - 32'd1);
    localparam logic signed [XPW:0]    BHALF  = (XPW+1)'(1) <<< (F - 1);
    localparam logic signed [SXPW-1:0] SHALF  = SXPW'(1) <<< (F - 1);
    localparam logic signed [SUMW-1:0] DHALF  = SUMW'(1) <<< (DS - 1);
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
    localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(32768);

    logic w_en;
    logic [T_OUT:1] r_vld;

    logic signed [15:0]   w_nin   [3];
    logic signed [NW-1:0] w_nwork [3];
    logic [16:0]          w_ax;
    logic [16:0]          w_ay;
    logic signed [NW-1:0] n_traw  [3];
    logic [15:0]          w_rh;
    logic [15:0]          w_rt;
    logic [CW-1:0]        w_cfull;

    logic signed [NW-1:0] r_n    [3];
    logic signed [NW-1:0] r_traw [3];
    logic [F:0]           r_c;
    logic [31:0]          r_phase;
    logic [2*F:0]         r_tsq  [3];
    logic [RW-1:0]        r_csq;
    logic [RW-1:0]        r_tss;
    logic [RW-1:0]        r_rad;

    logic [F+1:0]         w_len_t;
    logic [3*NW-1:0]      w_traw_d;
    logic signed [NW-1:0] w_t [3];
    logic [3*NW-1:0]      w_n_d;
    logic signed [NW-1:0] w_n [3];

    logic signed [XPW-1:0] r_xp   [6];
    logic signed [XPW:0]   n_bdif [3];
    logic signed [XPW:0]   n_brnd [3];
    logic signed [BW-1:0]  r_braw [3];
    logic [BSQW-1:0]       r_bsq  [3];
    logic [BSSW-1:0]       r_bss;
    logic [F+2:0]          w_len_b;
    logic [3*BW-1:0]       w_braw_d;
    logic signed [NW-1:0]  w_b [3];

    logic [6*NW-1:0]       w_tn_d;
    logic [F:0]            w_c_d;
    logic [F+1:0]          w_st;
    logic [F+1:0]          w_st_d;
    logic signed [BW-1:0]  w_cos;
    logic signed [BW-1:0]  w_sin;
    logic [2*BW-1:0]       w_cs_d;
    logic signed [SXPW-1:0] r_sxp;
    logic signed [SXPW-1:0] r_szp;
    logic signed [BW-1:0]  r_sx;
    logic signed [BW-1:0]  r_sz;

    logic signed [FPW-1:0] r_fp [3][3];
    logic signed [SUMW-1:0] n_sum [3];
    logic signed [SUMW-1:0] n_shr [3];
    logic signed [15:0]     r_dir [3];
    logic [95:0]            w_org;

    // Global advance: move when the output slot is free or being taken
    assign w_en          = !r_vld[T_OUT] || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;
    assign m_axis_tvalid = r_vld[T_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[T_OUT-1:1], s_axis_tvalid};
        end
    end

    // Unpack the input transaction
    assign w_nin[0] = s_axis_tdata[15:0];
    assign w_nin[1] = s_axis_tdata[31:16];
    assign w_nin[2] = s_axis_tdata[47:32];
    assign w_rh     = s_axis_tdata[63:48] & RMASK;
    assign w_rt     = s_axis_tdata[79:64] & RMASK;

    // Bring the normal to the working fraction width
    for (genvar k = 0; k < 3; k++) begin : g_work
        if (F >= 15) begin : g_up
            assign w_nwork[k] = NW'(w_nin[k]) <<< (F - 15);
        end else begin : g_down
            localparam logic signed [16:0] NHALF = 17'(1) <<< (14 - F);
            assign w_nwork[k] = NW'((17'(w_nin[k]) + NHALF) >>> (15 - F));
        end
    end

    assign w_ax = w_nin[0][15] ? (17'd0 - 17'(w_nin[0])) : 17'(w_nin[0]);
    assign w_ay = w_nin[1][15] ? (17'd0 - 17'(w_nin[1])) : 17'(w_nin[1]);

    // Pick the tangent from the two components chosen by |x| against |y|
    always_comb begin
        if (w_ax > w_ay) begin
            n_traw[0] = w_nwork[2];
            n_traw[1] = '0;
            n_traw[2] = -w_nwork[0];
        end else begin
            n_traw[0] = '0;
            n_traw[1] = -w_nwork[2];
            n_traw[2] = w_nwork[1];
        end
    end

    assign w_cfull = (CW'(w_rh) << F) + (CW'(1) << (RAND_BITS - 1));

    // Stage 1: normal, raw tangent, cosTheta, azimuth phase
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k]    <= w_nwork[k];
                r_traw[k] <= n_traw[k];
            end
            r_c     <= (F+1)'(w_cfull >> RAND_BITS);
            r_phase <= 32'(48'(w_rt) << (32 - RAND_BITS));
        end
    end

    // Stages 2 and 3: squared tangent length and 1 - cos^2
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_tsq[k] <= (2*F+1)'(XPW'(r_traw[k]) * XPW'(r_traw[k]));
            end
            r_csq <= RW'(r_c) * RW'(r_c);
            r_tss <= RW'(r_tsq[0]) + RW'(r_tsq[1]) + RW'(r_tsq[2]);
            r_rad <= (RW'(1) << (2 * F)) - r_csq;
        end
    end

    hds_sqrt #(.W(RW)) u_sqrt_t (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_tss),
        .o_root (w_len_t)
    );

    hds_sqrt #(.W(RW)) u_sqrt_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rad),
        .o_root (w_st)
    );

    hds_delay #(.W(3*NW), .D(2 + LS1)) u_dly_traw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_traw[2], r_traw[1], r_traw[0]}),
        .o_q   (w_traw_d)
    );

    hds_delay #(.W(3*NW), .D(T_TAN - 1)) u_dly_n (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_n[2], r_n[1], r_n[0]}),
        .o_q   (w_n_d)
    );

    // Normalize the tangent, one divider per component
    for (genvar k = 0; k < 3; k++) begin : g_tdiv
        assign w_n[k] = w_n_d[k*NW +: NW];
        hds_div #(.FRAC_BITS(F), .VW(NW), .LW(F + 2)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_val (w_traw_d[k*NW +: NW]),
            .i_len (w_len_t),
            .o_q   (w_t[k])
        );
    end

    // Cross product N x T: products, then difference with rounding
    always_comb begin
        n_bdif[0] = (XPW+1)'(r_xp[0]) - (XPW+1)'(r_xp[1]);
        n_bdif[1] = (XPW+1)'(r_xp[2]) - (XPW+1)'(r_xp[3]);
        n_bdif[2] = (XPW+1)'(r_xp[4]) - (XPW+1)'(r_xp[5]);
        for (int k = 0; k < 3; k++) begin
            n_brnd[k] = (n_bdif[k] + BHALF) >>> F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xp[0] <= XPW'(w_n[1]) * XPW'(w_t[2]);
            r_xp[1] <= XPW'(w_n[2]) * XPW'(w_t[1]);
            r_xp[2] <= XPW'(w_n[2]) * XPW'(w_t[0]);
            r_xp[3] <= XPW'(w_n[0]) * XPW'(w_t[2]);
            r_xp[4] <= XPW'(w_n[0]) * XPW'(w_t[1]);
            r_xp[5] <= XPW'(w_n[1]) * XPW'(w_t[0]);
            for (int k = 0; k < 3; k++) begin
                r_braw[k] <= BW'(n_brnd[k]);
                r_bsq[k]  <= BSQW'(BSSW'(r_braw[k]) * BSSW'(r_braw[k]));
            end
            r_bss <= BSSW'(r_bsq[0]) + BSSW'(r_bsq[1]) + BSSW'(r_bsq[2]);
        end
    end

    hds_sqrt #(.W(BSSW)) u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_bss),
        .o_root (w_len_b)
    );

    hds_delay #(.W(3*BW), .D(2 + LS2)) u_dly_braw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_braw[2], r_braw[1], r_braw[0]}),
        .o_q   (w_braw_d)
    );

    // Normalize the bitangent
    for (genvar k = 0; k < 3; k++) begin : g_bdiv
        hds_div #(.FRAC_BITS(F), .VW(BW), .LW(F + 3)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_val (w_braw_d[k*BW +: BW]),
            .i_len (w_len_b),
            .o_q   (w_b[k])
        );
    end

    // Hold tangent and normal until the bitangent is ready
    hds_delay #(.W(6*NW), .D(T_BIT - T_TAN)) u_dly_tn (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_t[2], w_t[1], w_t[0], w_n_d}),
        .o_q   (w_tn_d)
    );

    hds_delay #(.W(F + 1), .D(T_BIT - 1)) u_dly_c (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_c),
        .o_q   (w_c_d)
    );

    hds_cordic #(.FRAC_BITS(F)) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_phase),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    hds_delay #(.W(2*BW), .D(T_BIT - 2 - (1 + LC))) u_dly_cs (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_sin, w_cos}),
        .o_q   (w_cs_d)
    );

    hds_delay #(.W(F + 2), .D(T_BIT - 2 - (3 + LS1))) u_dly_st (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_st),
        .o_q   (w_st_d)
    );

    // Local sample: sinTheta times cos and sin of the azimuth
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sxp <= SXPW'($signed({1'b0, w_st_d})) * SXPW'($signed(w_cs_d[BW-1:0]));
            r_szp <= SXPW'($signed({1'b0, w_st_d})) * SXPW'($signed(w_cs_d[2*BW-1:BW]));
            r_sx  <= BW'((r_sxp + SHALF) >>> F);
            r_sz  <= BW'((r_szp + SHALF) >>> F);
        end
    end

    // Rotate into world space: sum, round to Q1.15, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = SUMW'(r_fp[k][0]) + SUMW'(r_fp[k][1]) + SUMW'(r_fp[k][2]);
            n_shr[k] = (n_sum[k] + DHALF) >>> DS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_fp[k][0] <= FPW'(r_sx) * FPW'($signed(w_tn_d[3*NW + k*NW +: NW]));
                r_fp[k][1] <= FPW'($signed({1'b0, w_c_d})) *
                              FPW'($signed(w_tn_d[k*NW +: NW]));
                r_fp[k][2] <= FPW'(r_sz) * FPW'(w_b[k]);
                if (n_shr[k] > SAT_HI) begin
                    r_dir[k] <= 16'sh7FFF;
                end else if (n_shr[k] < SAT_LO) begin
                    r_dir[k] <= -16'sh8000;
                end else begin
                    r_dir[k] <= 16'(n_shr[k]);
                end
            end
        end
    end

    hds_delay #(.W(96), .D(T_OUT)) u_dly_org (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (s_axis_tdata[175:80]),
        .o_q   (w_org)
    );

    assign m_axis_tdata = {r_dir[2], r_dir[1], r_dir[0], w_org};
endmodule

// ===== design/hds_checker.sv =====
`include "hemisphere_direction_sampler_assert.svh"

module hds_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [175:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    // A stalled result stays offered
    `HDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A stalled result keeps its payload
    `HDS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // No transaction enters while the output is blocked
    `HDS_ASSERT_NOW(a_in_block, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

    // An empty output slot always lets input in
    `HDS_ASSERT_NOW(a_in_open, !m_axis_tvalid, s_axis_tready)
endmodule

bind hemisphere_direction_sampler hds_checker u_hds_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Expected-direction store: predicts each sample from the accepted request
class direction_scoreboard;
    logic [143:0] pending_q[$];
    int errors;
    int checked;

    static longint unsigned atan_step[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    function new();
        errors = 0;
        checked = 0;
    endfunction

    // Round half up, dropping s fraction bits
    static function longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Integer square root rounded to nearest
    static function longint unsigned root_nearest(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v > r) r = r + 1;
        return r;
    endfunction

    // Scale a vector to unit length; a zero vector stays zero
    static function void unit_vector(ref longint v[3]);
        longint unsigned ss;
        longint unsigned len;
        longint unsigned m;
        longint unsigned q;
        ss = 0;
        for (int k = 0; k < 3; k++) ss = ss + longint'(v[k] * v[k]);
        len = root_nearest(ss);
        for (int k = 0; k < 3; k++) begin
            if (len == 0) begin
                v[k] = 0;
            end else begin
                m = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
                q = ((m << 15) + len / 2) / len;
                v[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    // Cosine and sine of a 32-bit turn phase
    static function void turn_sincos(longint unsigned phase, output longint co,
                                     output longint si);
        longint unsigned q;
        longint unsigned d;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint tmp;
        q = ((phase + (64'd1 << 29)) >> 30) & 3;
        d = (phase - (q << 30)) & 64'hFFFF_FFFF;
        z = (d >= (64'd1 << 31)) ? longint'(d) - (longint'(1) <<< 32) : longint'(d);
        x = round_shift(longint'(64'd2608131496), 17);
        y = 0;
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(atan_step[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(atan_step[i]);
            end
        end
        if (q == 1) begin
            tmp = x; x = -y; y = tmp;
        end else if (q == 2) begin
            x = -x; y = -y;
        end else if (q == 3) begin
            tmp = x; x = y; y = -tmp;
        end
        co = x;
        si = y;
    endfunction

    // Predict origin and world direction for one request
    static function logic [143:0] sample_direction(logic [175:0] req);
        longint n[3];
        longint t[3];
        longint b[3];
        longint c;
        longint st;
        longint cs;
        longint sn;
        longint sx;
        longint sz;
        longint d;
        longint unsigned rh;
        longint unsigned rt;
        logic [143:0] res;
        n[0] = longint'($signed(req[15:0]));
        n[1] = longint'($signed(req[31:16]));
        n[2] = longint'($signed(req[47:32]));
        rh = req[63:48];
        rt = req[79:64];
        if ((n[0] < 0 ? -n[0] : n[0]) > (n[1] < 0 ? -n[1] : n[1])) begin
            t[0] = n[2]; t[1] = 0; t[2] = -n[0];
        end else begin
            t[0] = 0; t[1] = -n[2]; t[2] = n[1];
        end
        unit_vector(t);
        b[0] = round_shift(n[1] * t[2] - n[2] * t[1], 15);
        b[1] = round_shift(n[2] * t[0] - n[0] * t[2], 15);
        b[2] = round_shift(n[0] * t[1] - n[1] * t[0], 15);
        unit_vector(b);
        c = longint'(((rh << 15) + (64'd1 << 15)) >> 16);
        st = longint'(root_nearest((64'd1 << 30) - longint'(c * c)));
        turn_sincos(rt << 16, cs, sn);
        sx = round_shift(st * cs, 15);
        sz = round_shift(st * sn, 15);
        res[95:0] = req[175:80];
        for (int k = 0; k < 3; k++) begin
            d = round_shift(sx * t[k] + c * n[k] + sz * b[k], 15);
            if (d > 32767) d = 32767;
            if (d < -32768) d = -32768;
            res[96 + 16 * k +: 16] = d[15:0];
        end
        return res;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0d: %s got %h want %h", checked, what, got, want);
        errors++;
    endtask

    // Note an accepted request
    function void note_request(logic [175:0] req);
        pending_q.push_back(sample_direction(req));
    endfunction

    // Check a delivered sample against the oldest prediction
    task check_sample(logic [143:0] got);
        logic [143:0] want;
        if (pending_q.size() == 0) begin
            report("unexpected sample", got[31:0], 32'd0);
        end else begin
            want = pending_q.pop_front();
            if (got[31:0] !== want[31:0]) report("ray_origin_x", got[31:0], want[31:0]);
            if (got[63:32] !== want[63:32]) report("ray_origin_y", got[63:32], want[63:32]);
            if (got[95:64] !== want[95:64]) report("ray_origin_z", got[95:64], want[95:64]);
            if (got[111:96] !== want[111:96])
                report("dir_x", {16'd0, got[111:96]}, {16'd0, want[111:96]});
            if (got[127:112] !== want[127:112])
                report("dir_y", {16'd0, got[127:112]}, {16'd0, want[127:112]});
            if (got[143:128] !== want[143:128])
                report("dir_z", {16'd0, got[143:128]}, {16'd0, want[143:128]});
        end
        checked++;
    endtask
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // normal_x, normal_y, normal_z, rand_height, rand_turn, origin_x, origin_y, origin_z
    logic [175:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // ray_origin_x, ray_origin_y, ray_origin_z, dir_x, dir_y, dir_z
    logic [143:0] m_axis_tdata;

    direction_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  tx_burst;
    bit  rx_burst;
    bit  rx_hold_req;

    hemisphere_direction_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Check every delivered sample and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
        if (!i_rst_n || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the block takes it
    task send_request(logic [175:0] req);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(req);
        sent++;
    endtask

    task send_fields(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [15:0] rh,
                     logic [15:0] rt, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        send_request({oz, oy, ox, rt, rh, nz, ny, nx});
    endtask

    // Random request: mostly near-unit normals, some raw noise
    function automatic logic [175:0] random_request();
        logic [15:0] nv[3];
        int axis;
        logic [15:0] mag;
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 3; k++) nv[k] = 16'($urandom);
        end else begin
            axis = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) nv[k] = 16'($urandom_range(0, 9000) - 4500);
            mag = 16'($urandom_range(30000, 32767));
            nv[axis] = $urandom_range(0, 1) ? mag : -mag;
        end
        return {32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom),
                16'($urandom), nv[2], nv[1], nv[0]};
    endfunction

    // Receiver: random hold-offs, with one long hold on request
    initial begin
        int w;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                w = 400;
                rx_hold_req = 1'b0;
            end else begin
                w = rx_burst ? 0 : $urandom_range(0, 13);
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        sb = new();
        idle_cycles = 0;
        sent = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        rx_hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axis normals, extremes, zero normal, ties, saturation
        send_fields(16'h7FFF, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_fields(0, 16'h7FFF, 0, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_fields(0, 0, 16'h7FFF, 16'h8000, 16'h4000, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF);
        send_fields(16'h8000, 0, 0, 16'h8000, 16'h8000, 0, 0, 32'h8000_0000);
        send_fields(0, 16'h8000, 0, 16'h4000, 16'hC000, 1, 2, 3);
        send_fields(0, 0, 16'h8000, 16'hC000, 16'h2000, 4, 5, 6);
        send_fields(0, 0, 0, 16'h8000, 16'h6000, 7, 8, 9);
        send_fields(0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(16'h5A82, 16'h5A82, 0, 16'h1000, 16'hE000, 10, 11, 12);
        send_fields(16'h5A82, 16'hA57E, 0, 16'hF000, 16'h1234, 13, 14, 15);
        send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0, 16, 17, 18);
        send_fields(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h8000, 19, 20, 21);
        send_fields(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001, 22, 23, 24);
        send_fields(16'h49E6, 16'h49E6, 16'h49E6, 16'h7FFF, 16'h5555, 25, 26, 27);
        send_fields(16'h0001, 0, 16'h7FFF, 16'hFFFE, 16'hFFFE, 28, 29, 30);
        send_fields(0, 16'h0001, 16'h8001, 16'h2000, 16'hA000, 31, 32, 33);

        // Pause until all outstanding samples are back
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);

        // Fill the pipeline behind a long receiver hold
        tx_burst = 1'b1;
        rx_hold_req = 1'b1;
        repeat (150) send_request(random_request());
        tx_burst = 1'b0;

        // Random phases, some at full rate on one side
        for (int ph = 0; ph < 8; ph++) begin
            tx_burst = (ph % 3 == 1);
            rx_burst = (ph % 4 == 2);
            repeat (205) send_request(random_request());
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests, %0d samples checked: axis, tie, zero and",
                 sent, sb.checked);
        $display("saturating normals, random normals, stalls and full-rate bursts");
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
